>>> rtl/sthi_pkg.sv
package sthi_pkg;

	// table sizing; the index depth is a power of two, the home slot is the low id bits
	localparam int CAPACITY    = 256;
	localparam int INDEX_SLOTS = 512;
	localparam int POS_W       = $clog2(CAPACITY);
	localparam int CAP_W       = $clog2(CAPACITY + 1);
	localparam int SLOT_W      = $clog2(INDEX_SLOTS);
	localparam int CNT_W       = $clog2(INDEX_SLOTS + 1);

	localparam logic [15:0] MAX_U16 = 16'hFFFF;
	localparam logic [15:0] ID_NONE = 16'h0000;

	// opcodes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_KILL = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [15:0] target_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] new_id;
		logic [7:0]  new_position;
		logic        moved;
		logic [15:0] moved_id;
		logic [7:0]  moved_position;
	} out_item_t;

	// command class decided by the front end
	typedef enum logic [1:0] {
		K_ADD,
		K_KILL,
		K_KILL_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] id;
	} cmd_t;

	// one hash index entry
	typedef struct packed {
		logic [15:0]      id;
		logic [POS_W-1:0] pos;
	} idx_entry_t;

	// position to the 8 bit output field
	function automatic logic [7:0] pos_to_field(logic [POS_W-1:0] p);
		logic [31:0] tmp;
		tmp = 32'(p);
		return tmp[7:0];
	endfunction

endpackage

>>> rtl/sthi_ram.sv
module sthi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> rtl/sthi_front.sv
module sthi_front
	import sthi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     hold,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     q_valid,
	output cmd_t     q_cmd,
	input  logic     q_pop
);

	cmd_t       fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       push;

	// classify the incoming item
	always_comb begin
		cls.id = in_data.target_id;
		if (in_data.opcode == OP_ADD) begin
			cls.kind = K_ADD;
		end else if (in_data.target_id == ID_NONE || in_data.target_id == MAX_U16) begin
			cls.kind = K_KILL_BAD;
		end else begin
			cls.kind = K_KILL;
		end
	end

	assign in_ready = (count_q != 2'd2) && !hold;
	assign push     = in_valid && in_ready;
	assign q_valid  = count_q != 2'd0;
	assign q_cmd    = fifo_q[rptr_q];

	// two entry command queue
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

>>> rtl/sthi_engine.sv
module sthi_engine
	import sthi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	output logic      clearing,
	input  logic      q_valid,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PRB_RD,
		S_PRB_CK,
		S_MID_RD,
		S_MID_CK,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_FREE,
		M_FIND_T,
		M_FIND_M
	} mode_t;

	state_t           state_q;
	mode_t            mode_q;
	logic [15:0]      key_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [POS_W-1:0] hole_q;
	logic [CAP_W-1:0] live_q;
	logic [15:0]      idc_q;
	out_item_t        res_q;
	out_item_t        out_q;
	logic             outv_q;

	logic             idx_we;
	logic [SLOT_W-1:0] idx_addr;
	idx_entry_t       idx_wdata;
	idx_entry_t       idx_rdata;
	logic             den_we;
	logic [POS_W-1:0] den_addr;
	logic [15:0]      den_wdata;
	logic [15:0]      den_rdata;

	logic             hit_free;
	logic             hit_key;
	logic             hit_zero;
	logic             sweep_end;
	logic             slot_last;
	logic [CAP_W-1:0] last_pos;

	sthi_ram #(.WIDTH($bits(idx_entry_t)), .DEPTH(INDEX_SLOTS)) u_index (
		.clk   (clk),
		.we    (idx_we),
		.addr  (idx_addr),
		.wdata (idx_wdata),
		.rdata (idx_rdata)
	);

	sthi_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_dense (
		.clk   (clk),
		.we    (den_we),
		.addr  (den_addr),
		.wdata (den_wdata),
		.rdata (den_rdata)
	);

	// probe decisions on the entry just read
	assign hit_free  = (mode_q == M_FREE) && (idx_rdata.id == ID_NONE || idx_rdata.id == MAX_U16);
	assign hit_key   = (mode_q != M_FREE) && (idx_rdata.id == key_q);
	assign hit_zero  = (mode_q != M_FREE) && (idx_rdata.id == ID_NONE);
	assign sweep_end = cnt_q == CNT_W'(INDEX_SLOTS - 1);
	assign slot_last = slot_q == SLOT_W'(INDEX_SLOTS - 1);
	assign last_pos  = live_q - CAP_W'(1);

	assign clearing  = state_q == S_CLEAR;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = outv_q;
	assign out_data  = out_q;

	// memory port control
	always_comb begin
		idx_we    = 1'b0;
		idx_addr  = slot_q;
		idx_wdata = '0;
		den_we    = 1'b0;
		den_addr  = live_q[POS_W-1:0];
		den_wdata = key_q;
		case (state_q)
			S_CLEAR: begin
				idx_we = 1'b1;
			end
			S_PRB_CK: begin
				if (hit_free) begin
					idx_we    = 1'b1;
					idx_wdata = '{id: key_q, pos: live_q[POS_W-1:0]};
					den_we    = 1'b1;
				end else if (hit_key && mode_q == M_FIND_T) begin
					idx_we    = 1'b1;
					idx_wdata = '{id: MAX_U16, pos: idx_rdata.pos};
				end else if (hit_key) begin
					idx_we    = 1'b1;
					idx_wdata = '{id: key_q, pos: hole_q};
				end
			end
			S_MID_CK: begin
				den_we    = 1'b1;
				den_addr  = hole_q;
				den_wdata = den_rdata;
			end
			default: begin
			end
		endcase
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && !outv_q) begin
			out_q <= res_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			mode_q  <= M_FREE;
			slot_q  <= '0;
			live_q  <= '0;
			idc_q   <= 16'd1;
			outv_q  <= 1'b0;
			key_q   <= '0;
			cnt_q   <= '0;
			hole_q  <= '0;
			res_q   <= '0;
		end else begin
			if (outv_q && out_ready) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					slot_q <= slot_last ? '0 : slot_q + SLOT_W'(1);
					if (slot_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						case (q_cmd.kind)
							K_ADD: begin
								if (live_q >= CAP_W'(CAPACITY)) begin
									res_q   <= '{status: ST_FULL, default: '0};
									state_q <= S_DONE;
								end else begin
									res_q   <= '0;
									key_q   <= idc_q;
									mode_q  <= M_FREE;
									state_q <= S_HASH;
								end
							end
							K_KILL: begin
								if (live_q == '0) begin
									res_q   <= '{status: ST_NOTFOUND, default: '0};
									state_q <= S_DONE;
								end else begin
									res_q   <= '0;
									key_q   <= q_cmd.id;
									mode_q  <= M_FIND_T;
									state_q <= S_HASH;
								end
							end
							default: begin
								res_q   <= '{status: ST_NOTFOUND, default: '0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_HASH: begin
					slot_q  <= key_q[SLOT_W-1:0];
					cnt_q   <= '0;
					state_q <= S_PRB_RD;
				end
				S_PRB_RD: begin
					state_q <= S_PRB_CK;
				end
				S_PRB_CK: begin
					if (hit_free) begin
						live_q  <= live_q + CAP_W'(1);
						idc_q   <= (key_q >= MAX_U16 - 16'd1) ? 16'd1 : key_q + 16'd1;
						res_q   <= '{status: ST_OK, new_id: key_q,
							new_position: pos_to_field(live_q[POS_W-1:0]), default: '0};
						state_q <= S_DONE;
					end else if (hit_key && mode_q == M_FIND_T) begin
						live_q <= last_pos;
						hole_q <= idx_rdata.pos;
						if (CAP_W'(idx_rdata.pos) < last_pos) begin
							state_q <= S_MID_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (hit_key || (hit_zero && mode_q == M_FIND_M)) begin
						res_q   <= '{status: ST_OK, moved: 1'b1, moved_id: key_q,
							moved_position: pos_to_field(hole_q), default: '0};
						state_q <= S_DONE;
					end else if (hit_zero || sweep_end) begin
						case (mode_q)
							M_FREE:   res_q <= '{status: ST_FULL, default: '0};
							M_FIND_T: res_q <= '{status: ST_NOTFOUND, default: '0};
							default: begin
								res_q <= '{status: ST_OK, moved: 1'b1, moved_id: key_q,
									moved_position: pos_to_field(hole_q), default: '0};
							end
						endcase
						state_q <= S_DONE;
					end else begin
						slot_q  <= slot_last ? '0 : slot_q + SLOT_W'(1);
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_PRB_RD;
					end
				end
				S_MID_RD: begin
					state_q <= S_MID_CK;
				end
				S_MID_CK: begin
					key_q   <= den_rdata;
					mode_q  <= M_FIND_M;
					state_q <= S_HASH;
				end
				S_DONE: begin
					if (!outv_q) begin
						outv_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CAP_W'(CAPACITY))
		else $error("live count above capacity");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop && !outv_q)
		else $error("command taken during index clear");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_cmd.kind == K_ADD && live_q >= CAP_W'(CAPACITY)) |=> $stable(live_q))
		else $error("live count changed on full add");

	a_idc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		idc_q != ID_NONE && idc_q != MAX_U16)
		else $error("reserved id in counter");
`endif

endmodule

>>> rtl/slot_table_with_hashed_id_index_core.sv
// channel  | valid      | ready      | payload
// input    | in_valid   | in_ready   | in_data  (in_item_t)
// output   | out_valid  | out_ready  | out_data (out_item_t)
//
// add and kill go from transfer through a hash step and, per probe, an index ram read and
// check to the result; a kill that moves the last entry also reads the moved id from the
// dense ram and walks a second probe; full adds, kills on an empty table and reserved
// ids go straight to the result. after reset the index is cleared with in_ready low.
// a two entry command queue keeps accepting while a result waits to be taken.
module slot_table_with_hashed_id_index_core
	import sthi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic clearing;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	// front: accept and classify
	sthi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (clearing),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	// back: probe and update the tables
	sthi_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
